// File: hdl/lca_pkg.sv
`default_nettype none

package lca_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned PROD_W = 17;
  localparam int unsigned TOTAL_W = 19;
  localparam int unsigned SUM_W = 22;
  localparam int unsigned GAIN_W = 15;
  localparam int unsigned RESP_W = 3;
  localparam int unsigned CFG_W = 64;
  localparam int unsigned IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_DRIVE = 3'd0;
  localparam logic [IDX_W-1:0] REG_START = 3'd1;
  localparam logic [IDX_W-1:0] REG_LEAK = 3'd2;
  localparam logic [IDX_W-1:0] REG_INHIB = 3'd3;
  localparam logic [IDX_W-1:0] REG_THRESH = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAXSTEP = 3'd5;
  localparam logic [IDX_W-1:0] REG_NONLIN = 3'd6;

  localparam logic signed [WORD_W-1:0] THRESH_RESET = 16'sd4096;
  localparam logic [WORD_W-1:0] MAXSTEP_RESET = 16'd1000;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [TOTAL_W-1:0] total_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic step;
    logic nonlin;
  } lane_ctl_t;

endpackage

`default_nettype wire

// File: hdl/lca_lane.sv
`default_nettype none

module lca_lane (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire lca_pkg::lane_ctl_t                 ctl,
  input  wire logic [lca_pkg::GAIN_W-1:0]         leak_gain,
  input  wire logic [lca_pkg::GAIN_W-1:0]         inhib_gain,
  input  wire lca_pkg::word_t                     drive,
  input  wire lca_pkg::word_t                     start,
  input  wire lca_pkg::word_t                     noise,
  input  wire lca_pkg::word_t                     threshold,
  input  wire lca_pkg::total_t                    total,
  output lca_pkg::prod_t                          inh_p,
  output logic                                    hit
);

  lca_pkg::word_t accum;
  lca_pkg::word_t noise_r;
  lca_pkg::prod_t leak_p;

  logic signed [lca_pkg::WORD_W-1:0] leak_g;
  logic signed [lca_pkg::WORD_W-1:0] inhib_g;
  logic signed [31:0] leak_mul;
  logic signed [31:0] inhib_mul;
  logic signed [32:0] leak_rnd;
  logic signed [32:0] inhib_rnd;

  lca_pkg::total_t other;
  logic signed [lca_pkg::SUM_W-1:0] sum;
  lca_pkg::word_t sat;
  lca_pkg::word_t accum_next;

  assign leak_g = {1'b0, leak_gain};
  assign inhib_g = {1'b0, inhib_gain};
  assign leak_mul = accum * leak_g;
  assign inhib_mul = accum * inhib_g;
  assign leak_rnd = 33'(leak_mul) + 33'sd16384;
  assign inhib_rnd = 33'(inhib_mul) + 33'sd16384;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      leak_p <= leak_rnd[31:15];
      inh_p <= inhib_rnd[31:15];
      noise_r <= noise;
    end
  end

  assign other = total - lca_pkg::total_t'(inh_p);

  always_comb begin
    sum = lca_pkg::SUM_W'(accum) + lca_pkg::SUM_W'(drive) - lca_pkg::SUM_W'(leak_p)
        - lca_pkg::SUM_W'(other) + lca_pkg::SUM_W'(noise_r);
    if (sum > 22'sd32767) begin
      sat = 16'sh7FFF;
    end else if (sum < -22'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[lca_pkg::WORD_W-1:0];
    end
    hit = sat >= threshold;
    if (ctl.nonlin && sat[lca_pkg::WORD_W-1]) begin
      accum_next = '0;
    end else begin
      accum_next = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= '0;
    end else if (ctl.load) begin
      accum <= start;
    end else if (ctl.step) begin
      accum <= accum_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lca_merge.sv
`default_nettype none

module lca_merge #(
  parameter int unsigned NUM_ACC = 4
) (
  input  wire lca_pkg::prod_t              inh_p [NUM_ACC],
  input  wire logic [NUM_ACC-1:0]          hit,
  output lca_pkg::total_t                  total,
  output logic [lca_pkg::RESP_W-1:0]       win_code
);

  always_comb begin
    total = '0;
    win_code = '0;
    for (int i = 0; i < NUM_ACC; i++) begin
      total = total + lca_pkg::total_t'(inh_p[i]);
      if (hit[i]) begin
        win_code = lca_pkg::RESP_W'(i + 1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/leaky_competing_accumulator_step_top.sv
// Leaky competing accumulator, one time step per input word.
// Configuration is written through wr_en, wr_index and wr_data while the
// block is idle; a write takes effect at the clock edge where wr_en is high.
// The input channel (in_valid, in_ready) carries cmd and four noise samples.
// A start word loads the start points; a step word advances every
// accumulator once, and is ignored when no trial is running.
// The output channel (out_valid, out_ready) returns one word per input word
// with trial_done, response and step_count as they stand after that word.
// An accepted word has its leak and inhibition products registered at the
// edge that accepts it, and the new accumulator values, winner test and
// result registered at a later edge, once the output register is free or
// its result is being taken; the block takes no new word until the word in
// flight has completed.
// A result held by a stalled receiver stays in the output register while the
// next word is accepted and has its products formed; that word completes as
// soon as the result is taken. Synchronous reset clears the accumulators and
// step count, marks no trial running and loads the register defaults.
`default_nettype none

module leaky_competing_accumulator_step_top #(
  parameter int unsigned NUM_ACC = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [lca_pkg::IDX_W-1:0]     wr_index,
  input  wire logic [lca_pkg::CFG_W-1:0]     wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          cmd,
  input  wire logic signed [15:0]            noise_a,
  input  wire logic signed [15:0]            noise_b,
  input  wire logic signed [15:0]            noise_c,
  input  wire logic signed [15:0]            noise_d,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               trial_done,
  output logic [2:0]                         response,
  output logic [15:0]                        step_count
);

  logic [lca_pkg::CFG_W-1:0] drive_words;
  logic [lca_pkg::CFG_W-1:0] start_words;
  logic [lca_pkg::GAIN_W-1:0] leak_gain;
  logic [lca_pkg::GAIN_W-1:0] inhib_gain;
  lca_pkg::word_t threshold;
  logic [15:0] max_steps;
  logic nonlinear_mode;

  logic busy;
  logic cmd_r;
  logic finished;
  logic [lca_pkg::RESP_W-1:0] winner_id;
  logic [15:0] steps_taken;

  logic commit;
  logic accept;
  lca_pkg::lane_ctl_t ctl;
  lca_pkg::word_t noise_arr [4];
  lca_pkg::prod_t inh_p [NUM_ACC];
  logic [NUM_ACC-1:0] hit;
  lca_pkg::total_t total;
  logic [lca_pkg::RESP_W-1:0] win_code;

  logic finished_next;
  logic [lca_pkg::RESP_W-1:0] winner_next;
  logic [15:0] steps_next;
  logic [15:0] steps_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_words <= '0;
      start_words <= '0;
      leak_gain <= '0;
      inhib_gain <= '0;
      threshold <= lca_pkg::THRESH_RESET;
      max_steps <= lca_pkg::MAXSTEP_RESET;
      nonlinear_mode <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        lca_pkg::REG_DRIVE: drive_words <= wr_data;
        lca_pkg::REG_START: start_words <= wr_data;
        lca_pkg::REG_LEAK: leak_gain <= wr_data[lca_pkg::GAIN_W-1:0];
        lca_pkg::REG_INHIB: inhib_gain <= wr_data[lca_pkg::GAIN_W-1:0];
        lca_pkg::REG_THRESH: threshold <= wr_data[15:0];
        lca_pkg::REG_MAXSTEP: max_steps <= wr_data[15:0];
        lca_pkg::REG_NONLIN: nonlinear_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready = !busy;
  assign accept = in_valid && in_ready;
  assign commit = busy && (!out_valid || out_ready);

  assign ctl.capture = accept;
  assign ctl.load = commit && !cmd_r;
  assign ctl.step = commit && cmd_r && !finished;
  assign ctl.nonlin = nonlinear_mode;

  assign noise_arr[0] = noise_a;
  assign noise_arr[1] = noise_b;
  assign noise_arr[2] = noise_c;
  assign noise_arr[3] = noise_d;

  for (genvar g = 0; g < NUM_ACC; g++) begin : g_lane
    lca_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .leak_gain  (leak_gain),
      .inhib_gain (inhib_gain),
      .drive      (drive_words[16*g +: 16]),
      .start      (start_words[16*g +: 16]),
      .noise      (noise_arr[g]),
      .threshold  (threshold),
      .total      (total),
      .inh_p      (inh_p[g]),
      .hit        (hit[g])
    );
  end

  lca_merge #(
    .NUM_ACC (NUM_ACC)
  ) u_merge (
    .inh_p    (inh_p),
    .hit      (hit),
    .total    (total),
    .win_code (win_code)
  );

  assign steps_inc = steps_taken + 16'd1;

  always_comb begin
    finished_next = finished;
    winner_next = winner_id;
    steps_next = steps_taken;
    if (!cmd_r) begin
      finished_next = 1'b0;
      winner_next = '0;
      steps_next = '0;
    end else if (!finished) begin
      steps_next = steps_inc;
      if (win_code != '0) begin
        winner_next = win_code;
      end
      finished_next = (win_code != '0) || (winner_id != '0) || (steps_inc >= max_steps);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      finished <= 1'b1;
      winner_id <= '0;
      steps_taken <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        cmd_r <= cmd;
      end else if (commit) begin
        busy <= 1'b0;
      end
      if (commit) begin
        out_valid <= 1'b1;
        trial_done <= finished_next;
        response <= winner_next;
        step_count <= steps_next;
        finished <= finished_next;
        winner_id <= winner_next;
        steps_taken <= steps_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    commit && !cmd_r |=> out_valid && !trial_done && response == '0 && step_count == '0)
    else $error("start word did not clear the trial result");

  a_resp_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && response != '0 |-> trial_done)
    else $error("response shown without a finished trial");

  a_resp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> response <= lca_pkg::RESP_W'(NUM_ACC))
    else $error("response names a lane that does not exist");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    busy && !out_valid |=> !busy && out_valid)
    else $error("word in flight did not complete with a free output register");

  a_ignored_step: assert property (@(posedge clk) disable iff (rst)
    commit && cmd_r && finished |=> step_count == $past(steps_taken) && trial_done)
    else $error("step after trial end changed the result");

endmodule

`default_nettype wire

// File: tb/sv/tb_leaky_competing_accumulator_step_top.sv
`timescale 1ns / 1ps

module tb_leaky_competing_accumulator_step_top;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP = 1'b1;
  localparam logic [lca_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int RANDOM_END = 1540;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic        done;
    logic [2:0]  response;
    logic [15:0] count;
  } trial_outcome_t;

  class trial_tracker;
    lca_pkg::word_t             acc [4];
    logic [15:0]                steps;
    logic                       done;
    logic [2:0]                 winner;
    logic [63:0]                drive_lanes;
    logic [63:0]                start_lanes;
    logic [lca_pkg::GAIN_W-1:0] leak;
    logic [lca_pkg::GAIN_W-1:0] inhib;
    lca_pkg::word_t             thresh;
    logic [15:0]                step_limit;
    logic                       clamp;
    trial_outcome_t             expected_outcomes [$];
    int                         errors;

    function new();
      foreach (acc[i]) acc[i] = '0;
      steps = '0;
      done = 1'b1;
      winner = '0;
      drive_lanes = '0;
      start_lanes = '0;
      leak = '0;
      inhib = '0;
      thresh = lca_pkg::THRESH_RESET;
      step_limit = lca_pkg::MAXSTEP_RESET;
      clamp = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [lca_pkg::IDX_W-1:0] idx, logic [lca_pkg::CFG_W-1:0] val);
      case (idx)
        lca_pkg::REG_DRIVE: drive_lanes = val;
        lca_pkg::REG_START: start_lanes = val;
        lca_pkg::REG_LEAK: leak = val[lca_pkg::GAIN_W-1:0];
        lca_pkg::REG_INHIB: inhib = val[lca_pkg::GAIN_W-1:0];
        lca_pkg::REG_THRESH: thresh = lca_pkg::word_t'(val[15:0]);
        lca_pkg::REG_MAXSTEP: step_limit = val[15:0];
        lca_pkg::REG_NONLIN: clamp = val[0];
        default: ;
      endcase
    endfunction

    // Q3.12 times Q0.15, rounded half up back to Q3.12.
    function longint scaled(lca_pkg::word_t x, logic [lca_pkg::GAIN_W-1:0] g);
      longint p;
      p = longint'(x) * longint'(g);
      return (p + 64'sd16384) >>> 15;
    endfunction

    function lca_pkg::word_t clip(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return lca_pkg::word_t'(v);
    endfunction

    function void note_word(logic c, lca_pkg::word_t na, lca_pkg::word_t nb,
                            lca_pkg::word_t nc, lca_pkg::word_t nd);
      lca_pkg::word_t noise [4];
      lca_pkg::word_t nx [4];
      longint         inh [4];
      longint         total;
      longint         v;
      trial_outcome_t o;
      noise = '{na, nb, nc, nd};
      if (c == CMD_START) begin
        for (int i = 0; i < 4; i++) acc[i] = lca_pkg::word_t'(start_lanes[16*i +: 16]);
        steps = '0;
        done = 1'b0;
        winner = '0;
      end else if (!done) begin
        total = 0;
        for (int i = 0; i < 4; i++) begin
          inh[i] = scaled(acc[i], inhib);
          total += inh[i];
        end
        for (int i = 0; i < 4; i++) begin
          v = longint'(acc[i]) + longint'(lca_pkg::word_t'(drive_lanes[16*i +: 16]))
              - scaled(acc[i], leak) - (total - inh[i]) + longint'(noise[i]);
          nx[i] = clip(v);
        end
        steps = steps + 16'd1;
        for (int i = 0; i < 4; i++) begin
          if (nx[i] >= thresh) winner = 3'(i + 1);
          if (clamp && nx[i] < 0) nx[i] = '0;
          acc[i] = nx[i];
        end
        if (winner != 0 || steps >= step_limit) done = 1'b1;
      end
      o.done = done;
      o.response = winner;
      o.count = steps;
      expected_outcomes.push_back(o);
    endfunction

    function void check_word(logic d, logic [2:0] r, logic [15:0] sc);
      trial_outcome_t o;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual done=%0d response=%0d steps=%0d",
                 $time, d, r, sc);
        errors++;
        return;
      end
      o = expected_outcomes.pop_front();
      if (d !== o.done) begin
        $display("%0t: trial_done expected %0d actual %0d", $time, o.done, d);
        errors++;
      end
      if (r !== o.response) begin
        $display("%0t: response expected %0d actual %0d", $time, o.response, r);
        errors++;
      end
      if (sc !== o.count) begin
        $display("%0t: step_count expected %0d actual %0d", $time, o.count, sc);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      wr_en = 1'b0;
  logic [lca_pkg::IDX_W-1:0] wr_index = '0;
  logic [lca_pkg::CFG_W-1:0] wr_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      cmd = 1'b0;
  lca_pkg::word_t            noise_a = '0;
  lca_pkg::word_t            noise_b = '0;
  lca_pkg::word_t            noise_c = '0;
  lca_pkg::word_t            noise_d = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      trial_done;
  logic [2:0]                response;
  logic [15:0]               step_count;

  trial_tracker tracker = new();
  bit           calm = 1'b0;
  int           words_sent = 0;
  int           rx_hold = 0;
  int           cycle_count = 0;

  leaky_competing_accumulator_step_top u_dut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .noise_a(noise_a),
    .noise_b(noise_b),
    .noise_c(noise_c),
    .noise_d(noise_d),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .trial_done(trial_done),
    .response(response),
    .step_count(step_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_wait();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic lca_pkg::word_t pick_noise();
    case ($urandom_range(0, 9))
      0: return lca_pkg::word_t'($urandom_range(0, 65535));
      1: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      default: return lca_pkg::word_t'(int'($urandom_range(0, 2400)) - 1200);
    endcase
  endfunction

  function automatic logic [63:0] pack4(lca_pkg::word_t a, lca_pkg::word_t b,
                                        lca_pkg::word_t c, lca_pkg::word_t d);
    return {d, c, b, a};
  endfunction

  function automatic logic [63:0] pick_lanes(int lo, int hi);
    logic [63:0] w;
    int          v;
    int          i;
    for (i = 0; i < 4; i++) begin
      if ($urandom_range(0, 5) == 0) v = $urandom_range(0, 65535);
      else v = lo + int'($urandom_range(0, hi - lo));
      w[16*i +: 16] = v[15:0];
    end
    return w;
  endfunction

  function automatic logic [63:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return 64'h7fff;
      2: return 64'($urandom_range(0, 32767));
      default: return 64'($urandom_range(0, 3000));
    endcase
  endfunction

  task automatic send_word(logic c, lca_pkg::word_t na, lca_pkg::word_t nb,
                           lca_pkg::word_t nc, lca_pkg::word_t nd);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    noise_a <= na;
    noise_b <= nb;
    noise_c <= nc;
    noise_d <= nd;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    tracker.note_word(c, na, nb, nc, nd);
  endtask

  task automatic send_step();
    send_word(CMD_STEP, pick_noise(), pick_noise(), pick_noise(), pick_noise());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.expected_outcomes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [lca_pkg::IDX_W-1:0] idx, logic [lca_pkg::CFG_W-1:0] val);
    drain();
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    tracker.write_reg(idx, val);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        tracker.check_word(trial_done, response, step_count);
        rx_hold = pick_wait();
      end
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold = rx_hold - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int phase;
    int phase_end;
    int n_steps;
    int k;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // A step word with no trial open is ignored.
    send_word(CMD_STEP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(CMD_START, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_word(CMD_STEP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(CMD_STEP, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_word(CMD_STEP, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);

    write_reg(lca_pkg::REG_DRIVE, pack4(16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff));
    write_reg(lca_pkg::REG_START, pack4(16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff));
    write_reg(lca_pkg::REG_LEAK, 64'h7fff);
    write_reg(lca_pkg::REG_INHIB, 64'h7fff);
    write_reg(lca_pkg::REG_THRESH, 64'h7fff);
    write_reg(lca_pkg::REG_MAXSTEP, 64'd0);
    write_reg(lca_pkg::REG_NONLIN, 64'd1);
    write_reg(REG_UNUSED, 64'hffff_ffff_ffff_ffff);
    send_word(CMD_START, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(CMD_STEP, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_word(CMD_STEP, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);

    write_reg(lca_pkg::REG_MAXSTEP, 64'd3);
    write_reg(lca_pkg::REG_THRESH, 64'h8000);
    write_reg(lca_pkg::REG_NONLIN, 64'd0);
    send_word(CMD_START, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(CMD_STEP, 16'sd1234, -16'sd1, 16'sd0, 16'sd77);

    write_reg(lca_pkg::REG_THRESH, 64'h7fff);
    write_reg(lca_pkg::REG_LEAK, 64'd0);
    write_reg(lca_pkg::REG_INHIB, 64'd0);
    write_reg(lca_pkg::REG_DRIVE, 64'd0);
    write_reg(lca_pkg::REG_START, 64'd0);
    write_reg(lca_pkg::REG_NONLIN, 64'd1);
    send_word(CMD_START, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(CMD_STEP, -16'sd100, -16'sd1, 16'sh8000, -16'sd5);
    send_word(CMD_STEP, 16'sd5, -16'sd5, 16'sd100, -16'sd100);
    send_word(CMD_STEP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);

    // Lowering the step limit below the running count ends the trial on the next step.
    write_reg(lca_pkg::REG_MAXSTEP, 64'd100);
    write_reg(lca_pkg::REG_THRESH, 64'd8000);
    write_reg(lca_pkg::REG_DRIVE, pack4(16'sd100, 16'sd100, 16'sd100, 16'sd100));
    send_word(CMD_START, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(CMD_STEP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(CMD_STEP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(CMD_STEP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    write_reg(lca_pkg::REG_MAXSTEP, 64'd2);
    send_word(CMD_STEP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);

    write_reg(lca_pkg::REG_MAXSTEP, 64'd100);
    write_reg(lca_pkg::REG_DRIVE, pack4(16'sd300, 16'sd300, 16'sd300, 16'sd300));
    write_reg(lca_pkg::REG_THRESH, 64'd200);
    send_word(CMD_START, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(CMD_STEP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);

    write_reg(lca_pkg::REG_DRIVE, 64'd0);
    write_reg(lca_pkg::REG_THRESH, 64'd2000);
    send_word(CMD_START, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(CMD_STEP, 16'sd3000, -16'sd3000, 16'sd2500, 16'sd0);

    for (phase = 0; words_sent < RANDOM_END; phase++) begin
      calm = ($urandom_range(0, 4) == 0);
      if (phase % 7 == 1) begin
        write_reg(lca_pkg::REG_DRIVE, {4{16'h7fff}});
        write_reg(lca_pkg::REG_START, {4{16'h7fff}});
        write_reg(lca_pkg::REG_LEAK, 64'h7fff);
        write_reg(lca_pkg::REG_INHIB, 64'h7fff);
        write_reg(lca_pkg::REG_THRESH, 64'h7fff);
        write_reg(lca_pkg::REG_MAXSTEP, 64'hffff);
        write_reg(lca_pkg::REG_NONLIN, 64'd1);
      end else if (phase % 7 == 2) begin
        write_reg(lca_pkg::REG_DRIVE, {4{16'h8000}});
        write_reg(lca_pkg::REG_START, {4{16'h8000}});
        write_reg(lca_pkg::REG_LEAK, 64'd0);
        write_reg(lca_pkg::REG_INHIB, 64'd0);
        write_reg(lca_pkg::REG_THRESH, 64'h8000);
        write_reg(lca_pkg::REG_MAXSTEP, 64'd1);
        write_reg(lca_pkg::REG_NONLIN, 64'd0);
      end else begin
        write_reg(lca_pkg::REG_DRIVE, pick_lanes(-150, 450));
        write_reg(lca_pkg::REG_START, pick_lanes(0, 3000));
        write_reg(lca_pkg::REG_LEAK, pick_gain());
        write_reg(lca_pkg::REG_INHIB, pick_gain());
        case ($urandom_range(0, 5))
          0: write_reg(lca_pkg::REG_THRESH, 64'h8000);
          1: write_reg(lca_pkg::REG_THRESH, 64'h7fff);
          2: write_reg(lca_pkg::REG_THRESH, 64'($urandom_range(0, 65535)));
          default: write_reg(lca_pkg::REG_THRESH, 64'($urandom_range(2000, 12000)));
        endcase
        case ($urandom_range(0, 7))
          0: write_reg(lca_pkg::REG_MAXSTEP, 64'd0);
          1: write_reg(lca_pkg::REG_MAXSTEP, 64'hffff);
          2: write_reg(lca_pkg::REG_MAXSTEP, 64'($urandom_range(0, 65535)));
          default: write_reg(lca_pkg::REG_MAXSTEP, 64'($urandom_range(1, 60)));
        endcase
        write_reg(lca_pkg::REG_NONLIN, 64'($urandom_range(0, 1)));
      end

      phase_end = words_sent + $urandom_range(40, 140);
      while (words_sent < phase_end && words_sent < RANDOM_END) begin
        send_word(CMD_START, pick_noise(), pick_noise(), pick_noise(), pick_noise());
        n_steps = $urandom_range(1, 70);
        for (k = 0; k < n_steps && !tracker.done; k++) begin
          if (k == 4 && $urandom_range(0, 19) == 0) begin
            write_reg(lca_pkg::REG_MAXSTEP, 64'($urandom_range(0, tracker.steps)));
          end
          send_step();
        end
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) send_step();
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_outcomes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
